>>> rtl/lct_pkg.sv
// ----------------------------------------------------------------------------
// lct_pkg
// shared types and constants of the thermometer linearizer
// ----------------------------------------------------------------------------
package lct_pkg;

  localparam int unsigned TableDepth = 48;
  localparam int unsigned TableAw    = 6;

  // input command kinds
  localparam logic CMD_CONVERT = 1'b0;
  localparam logic CMD_LOAD    = 1'b1;

  // words inside one range of the table
  localparam logic [3:0] W_LOWER = 4'd10;
  localparam logic [3:0] W_UPPER = 4'd11;
  localparam logic [3:0] W_COUNT = 4'd12;

  // log10(2) in Q0.32
  localparam logic [30:0] LOG10_2_Q32 = 31'h4D104D42;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_STEP,
    OP_RFIX,
    OP_NORM_STEP,
    OP_SQR_INIT,
    OP_SQR_STEP,
    OP_LMUL,
    OP_LADD,
    OP_SEL0,
    OP_SEL1,
    OP_LO,
    OP_HI,
    OP_CNT,
    OP_NUM,
    OP_ZN_INIT,
    OP_ZN_STEP,
    OP_ZN_FIN,
    OP_SER_INIT,
    OP_SER_MUL,
    OP_SER_ACC,
    OP_BELOW,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [3:0] rd_word;
    logic       rd_term;
  } dp_cmd_t;

  typedef struct packed {
    logic below;
    logic r_top;
    logic zn_div;
    logic ser_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/lct_ram.sv
// ----------------------------------------------------------------------------
// lct_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module lct_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/lct_datapath.sv
// ----------------------------------------------------------------------------
// lct_datapath
// divider, log unit, range select, normalizer and chebyshev recurrence
// ----------------------------------------------------------------------------
module lct_datapath #(
  parameter int unsigned MaxTerms = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lct_pkg::dp_cmd_t              cmd_i,
  output lct_pkg::dp_stat_t             stat_o,
  input  logic [31:0]                   sample_i,
  input  logic [19:0]                   current_i,
  input  logic                          tbl_we_i,
  input  logic [lct_pkg::TableAw-1:0]   tbl_waddr_i,
  input  logic [31:0]                   tbl_wdata_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [31:0]                   out_temp_o,
  output logic [1:0]                    out_range_o,
  output logic                          out_below_o,
  output logic                          out_clamped_o
);
  import lct_pkg::*;

  localparam int unsigned CntW = $clog2(MaxTerms + 1);

  logic [31:0] rd_data;
  logic [TableAw-1:0] raddr;

  // divider
  logic [47:0] r_q, r_d;
  logic [19:0] rem_q, rem_d, cur_q, cur_d;
  logic        curz_q, curz_d;
  // log
  logic [4:0]  sh_q, sh_d, e_q, e_d;
  logic [30:0] m_q, m_d;
  logic [27:0] frac_q, frac_d;
  logic [58:0] p_q, p_d;
  logic [32:0] z_q, z_d;
  // range and normalization
  logic [1:0]  rg_q, rg_d;
  logic signed [31:0] zl_q, zl_d, zu_q, zu_d;
  logic [CntW-1:0] count_q, count_d, ti_q, ti_d;
  logic [34:0] an_q, an_d;
  logic [33:0] ad_q, ad_d, zrem_q, zrem_d;
  logic        neg_q, neg_d, clamp_q, clamp_d;
  logic [29:0] q_q, q_d;
  logic signed [31:0] zn_q, zn_d;
  // series
  logic signed [33:0] tp_q, tp_d, tc_q, tc_d;
  logic signed [65:0] pc_q, pc_d, pt_q, pt_d;
  logic signed [39:0] acc_q, acc_d;
  // output
  logic        ov_q, ov_d;
  logic [31:0] otemp_q, otemp_d;
  logic [1:0]  orange_q, orange_d;
  logic        obelow_q, obelow_d, oclamp_q, oclamp_d;

  // combinational helpers
  logic [20:0] div_rs;
  logic        div_ge;
  logic [61:0] sq;
  logic [31:0] m2;
  logic [35:0] ec;
  logic [64:0] lsum;
  logic signed [33:0] zcmp, rdcmp;
  logic signed [35:0] zs, zl36, zu36, num, den;
  logic [34:0] zt;
  logic        zge;
  logic signed [31:0] coef;
  logic signed [65:0] pcr, ptr, tshift;
  logic signed [65:0] tsum;
  logic signed [31:0] cnt_word;

  assign raddr = {rg_q, (cmd_i.rd_term ? 4'(ti_q) : cmd_i.rd_word)};

  lct_ram #(.Width(32), .Depth(TableDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we_i),
    .waddr_i (tbl_waddr_i),
    .wdata_i (tbl_wdata_i),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  always_comb begin
    div_rs  = {rem_q, r_q[47]};
    div_ge  = div_rs >= {1'b0, cur_q};
    sq      = m_q * m_q;
    m2      = sq[61:30];
    ec      = 36'(e_q) * 36'(LOG10_2_Q32);
    lsum    = 65'(p_q) + (65'(ec) << 28) + 65'(33'h080000000);
    zcmp    = $signed({1'b0, z_q});
    rdcmp   = 34'($signed(rd_data));
    zs      = $signed({3'b000, z_q});
    zl36    = 36'(zl_q);
    zu36    = 36'(zu_q);
    num     = (zs <<< 1) - zl36 - zu36;
    den     = zu36 - zl36;
    zt      = {zrem_q, 1'b0};
    zge     = zt >= {1'b0, ad_q};
    coef    = $signed(rd_data);
    pcr     = pc_q + 66'sd536870912;
    ptr     = pt_q + 66'sd268435456;
    tshift  = ptr >>> 29;
    tsum    = pcr >>> 30;
    cnt_word = $signed(rd_data);
  end

  always_comb begin
    r_d = r_q;   rem_d = rem_q;  cur_d = cur_q;  curz_d = curz_q;
    sh_d = sh_q; e_d = e_q;      m_d = m_q;      frac_d = frac_q;
    p_d = p_q;   z_d = z_q;      rg_d = rg_q;    zl_d = zl_q;   zu_d = zu_q;
    count_d = count_q; ti_d = ti_q; an_d = an_q; ad_d = ad_q;
    zrem_d = zrem_q;   neg_d = neg_q; clamp_d = clamp_q; q_d = q_q; zn_d = zn_q;
    tp_d = tp_q; tc_d = tc_q; pc_d = pc_q; pt_d = pt_q; acc_d = acc_q;
    otemp_d = otemp_q; orange_d = orange_q; obelow_d = obelow_q; oclamp_d = oclamp_q;
    ov_d = ov_q & ~out_ready_i;

    unique case (cmd_i.op)
      OP_LOAD: begin
        r_d = {sample_i, 16'h0000};
        rem_d = '0;
        cur_d = current_i;
        curz_d = (current_i == '0);
        rg_d = '0;
        clamp_d = 1'b0;
        sh_d = '0;
      end
      OP_DIV_STEP: begin
        rem_d = div_ge ? 20'(div_rs - {1'b0, cur_q}) : div_rs[19:0];
        r_d = {r_q[46:0], div_ge};
      end
      OP_RFIX: begin
        if (curz_q) begin
          r_d = '1;
        end
      end
      OP_NORM_STEP: begin
        r_d = {r_q[46:0], 1'b0};
        sh_d = sh_q + 5'd1;
      end
      OP_SQR_INIT: begin
        m_d = r_q[47:17];
        e_d = 5'd31 - sh_q;
        frac_d = '0;
      end
      OP_SQR_STEP: begin
        m_d = m2[31] ? m2[31:1] : m2[30:0];
        frac_d = {frac_q[26:0], m2[31]};
      end
      OP_LMUL: p_d = 59'(frac_q) * 59'(LOG10_2_Q32);
      OP_LADD: z_d = lsum[64:32];
      OP_SEL0: begin
        if (zcmp < rdcmp) begin
          rg_d = 2'd1;
        end
      end
      OP_SEL1: begin
        if (rg_q == 2'd1 && zcmp < rdcmp) begin
          rg_d = 2'd2;
        end
      end
      OP_LO: zl_d = $signed(rd_data);
      OP_HI: zu_d = $signed(rd_data);
      OP_CNT: begin
        priority if (cnt_word < 32'sd2) begin
          count_d = CntW'(2);
        end else if (cnt_word > $signed(32'(MaxTerms))) begin
          count_d = CntW'(MaxTerms);
        end else begin
          count_d = CntW'(cnt_word);
        end
      end
      OP_NUM: begin
        neg_d = num[35] ^ den[35];
        an_d = num[35] ? 35'(-num) : num[34:0];
        ad_d = den[35] ? 34'(-den) : den[33:0];
      end
      OP_ZN_INIT: begin
        zrem_d = an_q[33:0];
        q_d = '0;
        priority if (an_q == '0) begin
          zn_d = '0;
        end else if (ad_q == '0 || an_q > {1'b0, ad_q}) begin
          zn_d = neg_q ? -32'sd1073741824 : 32'sd1073741824;
          clamp_d = 1'b1;
        end else if (an_q == {1'b0, ad_q}) begin
          zn_d = neg_q ? -32'sd1073741824 : 32'sd1073741824;
        end else begin
          zn_d = zn_q;
        end
      end
      OP_ZN_STEP: begin
        zrem_d = zge ? 34'(zt - {1'b0, ad_q}) : zt[33:0];
        q_d = {q_q[28:0], zge};
      end
      OP_ZN_FIN: zn_d = neg_q ? -$signed({2'b00, q_q}) : $signed({2'b00, q_q});
      OP_SER_INIT: begin
        ti_d = '0;
        acc_d = '0;
        tc_d = 34'sd1073741824;
        tp_d = 34'(zn_q);
      end
      OP_SER_MUL: begin
        pc_d = coef * tc_q;
        pt_d = zn_q * tc_q;
      end
      OP_SER_ACC: begin
        acc_d = acc_q + 40'(tsum);
        tc_d = 34'(tshift) - tp_q;
        tp_d = tc_q;
        ti_d = ti_q + CntW'(1);
      end
      OP_BELOW: begin
        ov_d = 1'b1;
        otemp_d = '0;
        orange_d = '0;
        obelow_d = 1'b1;
        oclamp_d = 1'b0;
      end
      OP_FINISH: begin
        ov_d = 1'b1;
        priority if (acc_q > 40'sd2147483647) begin
          otemp_d = 32'h7FFFFFFF;
        end else if (acc_q < -40'sd2147483648) begin
          otemp_d = 32'h80000000;
        end else begin
          otemp_d = acc_q[31:0];
        end
        orange_d = rg_q;
        obelow_d = 1'b0;
        oclamp_d = clamp_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;   rem_q <= rem_d; cur_q <= cur_d; curz_q <= curz_d;
    sh_q <= sh_d; e_q <= e_d;     m_q <= m_d;     frac_q <= frac_d;
    p_q <= p_d;   z_q <= z_d;     rg_q <= rg_d;   zl_q <= zl_d;   zu_q <= zu_d;
    count_q <= count_d; ti_q <= ti_d; an_q <= an_d; ad_q <= ad_d;
    zrem_q <= zrem_d;   neg_q <= neg_d; clamp_q <= clamp_d; q_q <= q_d; zn_q <= zn_d;
    tp_q <= tp_d; tc_q <= tc_d; pc_q <= pc_d; pt_q <= pt_d; acc_q <= acc_d;
    otemp_q <= otemp_d; orange_q <= orange_d; obelow_q <= obelow_d; oclamp_q <= oclamp_d;
  end

  assign stat_o.below    = (r_q[47:16] == '0);
  assign stat_o.r_top    = r_q[47];
  assign stat_o.zn_div   = (an_q != '0) && (ad_q != '0) && (an_q < {1'b0, ad_q});
  assign stat_o.ser_last = (ti_q == count_q - CntW'(1));
  assign stat_o.out_free = ~ov_q | out_ready_i;

  assign out_valid_o   = ov_q;
  assign out_temp_o    = otemp_q;
  assign out_range_o   = orange_q;
  assign out_below_o   = obelow_q;
  assign out_clamped_o = oclamp_q;

endmodule

>>> rtl/lct_ctrl.sv
// ----------------------------------------------------------------------------
// lct_ctrl
// sequencer that steps the datapath through one conversion
// ----------------------------------------------------------------------------
module lct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_convert_i,
  output logic              in_ready_o,
  input  lct_pkg::dp_stat_t stat_i,
  output lct_pkg::dp_cmd_t  cmd_o
);
  import lct_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DIV   = 5'd1;
  localparam logic [4:0] S_RFIX  = 5'd2;
  localparam logic [4:0] S_TEST  = 5'd3;
  localparam logic [4:0] S_NORM  = 5'd4;
  localparam logic [4:0] S_SQR   = 5'd5;
  localparam logic [4:0] S_LMUL  = 5'd6;
  localparam logic [4:0] S_LADD  = 5'd7;
  localparam logic [4:0] S_RD0   = 5'd8;
  localparam logic [4:0] S_SEL0  = 5'd9;
  localparam logic [4:0] S_RD1   = 5'd10;
  localparam logic [4:0] S_SEL1  = 5'd11;
  localparam logic [4:0] S_RDL   = 5'd12;
  localparam logic [4:0] S_LO    = 5'd13;
  localparam logic [4:0] S_HI    = 5'd14;
  localparam logic [4:0] S_CNT   = 5'd15;
  localparam logic [4:0] S_NUM   = 5'd16;
  localparam logic [4:0] S_ZCHK  = 5'd17;
  localparam logic [4:0] S_ZDIV  = 5'd18;
  localparam logic [4:0] S_ZFIN  = 5'd19;
  localparam logic [4:0] S_SINIT = 5'd20;
  localparam logic [4:0] S_SRD   = 5'd21;
  localparam logic [4:0] S_SMUL  = 5'd22;
  localparam logic [4:0] S_SACC  = 5'd23;
  localparam logic [4:0] S_FIN   = 5'd24;

  logic [4:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q + 6'd1;
    cmd_o = '{op: OP_NONE, rd_word: W_LOWER, rd_term: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_convert_i) begin
          cmd_o.op = OP_LOAD;
          state_d = S_DIV;
          cnt_d = '0;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (cnt_q == 6'd47) begin
          state_d = S_RFIX;
        end
      end
      S_RFIX: begin
        cmd_o.op = OP_RFIX;
        state_d = S_TEST;
      end
      S_TEST: begin
        if (!stat_i.below) begin
          state_d = S_NORM;
        end else if (stat_i.out_free) begin
          cmd_o.op = OP_BELOW;
          state_d = S_IDLE;
        end
      end
      S_NORM: begin
        if (stat_i.r_top) begin
          cmd_o.op = OP_SQR_INIT;
          state_d = S_SQR;
          cnt_d = '0;
        end else begin
          cmd_o.op = OP_NORM_STEP;
        end
      end
      S_SQR: begin
        cmd_o.op = OP_SQR_STEP;
        if (cnt_q == 6'd27) begin
          state_d = S_LMUL;
        end
      end
      S_LMUL: begin
        cmd_o.op = OP_LMUL;
        state_d = S_LADD;
      end
      S_LADD: begin
        cmd_o.op = OP_LADD;
        state_d = S_RD0;
      end
      S_RD0: state_d = S_SEL0;
      S_SEL0: begin
        cmd_o.op = OP_SEL0;
        state_d = S_RD1;
      end
      S_RD1: state_d = S_SEL1;
      S_SEL1: begin
        cmd_o.op = OP_SEL1;
        state_d = S_RDL;
      end
      S_RDL: state_d = S_LO;
      S_LO: begin
        cmd_o.op = OP_LO;
        cmd_o.rd_word = W_UPPER;
        state_d = S_HI;
      end
      S_HI: begin
        cmd_o.op = OP_HI;
        cmd_o.rd_word = W_COUNT;
        state_d = S_CNT;
      end
      S_CNT: begin
        cmd_o.op = OP_CNT;
        state_d = S_NUM;
      end
      S_NUM: begin
        cmd_o.op = OP_NUM;
        state_d = S_ZCHK;
      end
      S_ZCHK: begin
        cmd_o.op = OP_ZN_INIT;
        cnt_d = '0;
        state_d = stat_i.zn_div ? S_ZDIV : S_SINIT;
      end
      S_ZDIV: begin
        cmd_o.op = OP_ZN_STEP;
        if (cnt_q == 6'd29) begin
          state_d = S_ZFIN;
        end
      end
      S_ZFIN: begin
        cmd_o.op = OP_ZN_FIN;
        state_d = S_SINIT;
      end
      S_SINIT: begin
        cmd_o.op = OP_SER_INIT;
        state_d = S_SRD;
      end
      S_SRD: begin
        cmd_o.rd_term = 1'b1;
        state_d = S_SMUL;
      end
      S_SMUL: begin
        cmd_o.op = OP_SER_MUL;
        state_d = S_SACC;
      end
      S_SACC: begin
        cmd_o.op = OP_SER_ACC;
        state_d = stat_i.ser_last ? S_FIN : S_SRD;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_FINISH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/log_chebyshev_temperature_conversion.sv
// ----------------------------------------------------------------------------
// log_chebyshev_temperature_conversion
// resistance thermometer linearizer: voltage to kelvin via log10 and a
// chebyshev series over a three range coefficient table
// ----------------------------------------------------------------------------
// channel  | direction | payload
// s_axis   | in        | tuser command, tdata sample / table address / value
// m_axis   | out       | tdata temperature, range, below one ohm, clamped
// apb      | in        | excitation current register at byte address 0
//
// a conversion does the bit serial voltage/current divide; below one ohm it then
// offers its result, otherwise it normalizes, squares in the log loop, does the
// normalizing divide when it is needed and reads each series term in turn on
// the single table read port
// a load transfer writes the table in the cycle it is accepted
// reset clears control and the current register only; the table is undefined until written
// a held result stalls the next conversion only at its final step
// ----------------------------------------------------------------------------
module log_chebyshev_temperature_conversion #(
  parameter int unsigned MAX_TERMS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] sample_voltage_nv, [37:32] table_address, [69:38] table_value
  input  logic [71:0] s_axis_tdata,
  // [0] command
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] temperature_k, [33:32] range_used, [34] below_one_ohm, [35] clamped
  output logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lct_pkg::*;

  logic [19:0] cur_q;
  logic        s_xfer, tbl_we;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] temp;
  logic [1:0]  rng;
  logic        below, clamped;

  // config register, always ready with no wait states
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {12'h000, cur_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= 20'd10000;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      cur_q <= pwdata[19:0];
    end
  end

  // table loads go straight to the ram; addresses past the table are dropped
  assign s_xfer = s_axis_tvalid & s_axis_tready;
  assign tbl_we = s_xfer && (s_axis_tuser == CMD_LOAD) &&
                  (s_axis_tdata[37:32] < TableAw'(TableDepth));

  lct_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_convert_i (s_axis_tuser == CMD_CONVERT),
    .in_ready_o   (s_axis_tready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  lct_datapath #(.MaxTerms(MAX_TERMS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .sample_i      (s_axis_tdata[31:0]),
    .current_i     (cur_q),
    .tbl_we_i      (tbl_we),
    .tbl_waddr_i   (s_axis_tdata[37:32]),
    .tbl_wdata_i   (s_axis_tdata[69:38]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_temp_o    (temp),
    .out_range_o   (rng),
    .out_below_o   (below),
    .out_clamped_o (clamped)
  );

  assign m_axis_tdata = {4'h0, clamped, below, rng, temp};

endmodule

>>> rtl/lct_checker.sv
// ----------------------------------------------------------------------------
// lct_checker
// port level checks of the linearizer, bound to the top level
// ----------------------------------------------------------------------------
module lct_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import lct_pkg::*;

  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // below one ohm forces a zero result with no range and no clamp
  a_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[34] |->
      m_axis_tdata[31:0] == '0 && m_axis_tdata[33:32] == 2'd0 && !m_axis_tdata[35])
    else $error("below one ohm result not cleared");

  // only three ranges exist
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3)
    else $error("range out of table");

  // a conversion occupies the block
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_CONVERT |=> !s_axis_tready)
    else $error("input taken during a conversion");

endmodule

bind log_chebyshev_temperature_conversion lct_checker u_lct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
